FILE: rtl/core/lsrc_pkg.sv
// Package for the line segment clipper: microcode word layout, step addresses
// and the control store. Used by lsrc_seq and line_segment_rect_clipper_top.
// No dependencies.
`default_nettype none

package lsrc_pkg;

   localparam int PC_BITS    = 4;
   localparam int MAX_PASSES = 4;
   localparam int PASS_BITS  = 3;

   // Datapath action selected by the current control word.
   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_LOAD,
      ACT_SETUP,
      ACT_MUL1,
      ACT_MUL2,
      ACT_ADD,
      ACT_DIV_LOAD,
      ACT_DIV_STEP,
      ACT_WRITE,
      ACT_EMIT_OK,
      ACT_EMIT_REJ
   } act_type;

   // Sequencing rule of the current control word.
   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_GOTO,
      SEQ_WAIT_REQ,
      SEQ_IF_DONE,
      SEQ_IF_REJ,
      SEQ_LOOP,
      SEQ_WAIT_OUT
   } seq_type;

   typedef struct packed {
      act_type              act;
      seq_type              seq;
      logic [PC_BITS-1:0]   target;
   } ctrl_word_type;

   // Conditions the datapath reports back to the sequencer.
   typedef struct packed {
      logic req_fire;
      logic seg_done;
      logic seg_reject;
      logic div_more;
      logic out_busy;
   } seq_status_type;

   localparam logic [PC_BITS-1:0] PC_IDLE     = 4'd0;
   localparam logic [PC_BITS-1:0] PC_TEST     = 4'd1;
   localparam logic [PC_BITS-1:0] PC_SETUP    = 4'd2;
   localparam logic [PC_BITS-1:0] PC_MUL1     = 4'd3;
   localparam logic [PC_BITS-1:0] PC_MUL2     = 4'd4;
   localparam logic [PC_BITS-1:0] PC_ADD      = 4'd5;
   localparam logic [PC_BITS-1:0] PC_DIV_LOAD = 4'd6;
   localparam logic [PC_BITS-1:0] PC_DIV_STEP = 4'd7;
   localparam logic [PC_BITS-1:0] PC_WRITE    = 4'd8;
   localparam logic [PC_BITS-1:0] PC_EMIT_OK  = 4'd9;
   localparam logic [PC_BITS-1:0] PC_EMIT_REJ = 4'd10;

   // Control store: one word per step of the clip program.
   function automatic ctrl_word_type ucode_rom(input logic [PC_BITS-1:0] addr);
      ctrl_word_type w;
      w = '{act: ACT_NOP, seq: SEQ_GOTO, target: PC_IDLE};
      case (addr)
         PC_IDLE:     w = '{act: ACT_LOAD,     seq: SEQ_WAIT_REQ, target: PC_IDLE};
         PC_TEST:     w = '{act: ACT_NOP,      seq: SEQ_IF_DONE,  target: PC_EMIT_OK};
         PC_SETUP:    w = '{act: ACT_SETUP,    seq: SEQ_IF_REJ,   target: PC_EMIT_REJ};
         PC_MUL1:     w = '{act: ACT_MUL1,     seq: SEQ_NEXT,     target: PC_IDLE};
         PC_MUL2:     w = '{act: ACT_MUL2,     seq: SEQ_NEXT,     target: PC_IDLE};
         PC_ADD:      w = '{act: ACT_ADD,      seq: SEQ_NEXT,     target: PC_IDLE};
         PC_DIV_LOAD: w = '{act: ACT_DIV_LOAD, seq: SEQ_NEXT,     target: PC_IDLE};
         PC_DIV_STEP: w = '{act: ACT_DIV_STEP, seq: SEQ_LOOP,     target: PC_DIV_STEP};
         PC_WRITE:    w = '{act: ACT_WRITE,    seq: SEQ_GOTO,     target: PC_TEST};
         PC_EMIT_OK:  w = '{act: ACT_EMIT_OK,  seq: SEQ_WAIT_OUT, target: PC_IDLE};
         PC_EMIT_REJ: w = '{act: ACT_EMIT_REJ, seq: SEQ_WAIT_OUT, target: PC_IDLE};
         default:     w = '{act: ACT_NOP,      seq: SEQ_GOTO,     target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/line_segment_rect_clipper_top.sv
// Cohen-Sutherland line clipper against a rectangular window. A request
// carries one segment; the response carries an accepted flag and the clipped
// endpoints, or zeros when the segment is rejected. The block works on one
// segment at a time, driven by a short microprogram. Most of each clip pass
// is spent in the one-bit-per-cycle restoring divider that computes the
// intersection; one multiplier is shared by the two products of a pass. A
// segment needs up to four passes plus the load, test and response steps. A
// finished response waits in an output register while the next request is
// taken. The window registers are written through the csr port; the user must
// write them only while the block is idle, as the block does not enforce it.
// Depends on lsrc_pkg and lsrc_seq.
`default_nettype none

module line_segment_rect_clipper_top #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Window registers: index 0 left, 1 right, 2 bottom, 3 top.
   input  wire logic                                  csr_we,
   input  wire logic [1:0]                            csr_index,
   input  wire logic [COORD_BITS-1:0]                 csr_wdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // From bit 0 up: start_x, start_y, end_x, end_y, zero fill to whole bytes.
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // From bit 0 up: clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero fill.
   output logic [((4*COORD_BITS+7)/8)*8-1:0]          rsp_tdata,
   // accepted
   output logic                                       rsp_tuser
);
   import lsrc_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int D      = COORD_BITS + 1;
   localparam int A      = 2 * D + 1;
   localparam int DATA_W = ((4*COORD_BITS+7)/8)*8;
   localparam int CNT_W  = $clog2(COORD_BITS + 1);

   ctrl_word_type  ctrl;
   seq_status_type status;

   // Window registers.
   logic signed [C-1:0] win_left_ff, win_right_ff, win_bottom_ff, win_top_ff;

   // Endpoint registers.
   logic signed [C-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [C-1:0] x1_in, y1_in, x2_in, y2_in;

   // Per-pass operands.
   logic                axis_x_ff, first_ff;
   logic signed [C-1:0] bnd_ff, u1_ff;
   logic signed [D-1:0] dv_ff, du_ff, bv_ff;
   logic [PASS_BITS-1:0] pass_ff;

   // Multiplier, accumulator and divider.
   logic signed [2*D-1:0] prod_ff, prod_in;
   logic signed [D-1:0]   mul_a, mul_b;
   logic signed [A-1:0]   acc_ff;
   logic [A-1:0]          nmag;
   logic [D-1:0]          dmag_ff, dmag_in;
   logic [D-1:0]          rem_ff, rem_in;
   logic [C-1:0]          quo_ff, quo_in;
   logic                  neg_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [D:0]            shifted, trial;

   // Output register.
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic [4*C-1:0]      rsp_coord_ff;
   logic                out_busy, req_fire, emit;

   logic [3:0]          c1, c2, csel;
   logic                sel_first, sel_axis_x;
   logic signed [C-1:0] sel_bnd, sel_u1, sel_v1;
   logic signed [D-1:0] dx, dy;
   logic [C-1:0]        qv;
   logic signed [C-1:0] new_u;

   lsrc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_tready = (ctrl.seq == SEQ_WAIT_REQ);
   assign req_fire   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign emit       = ((ctrl.act == ACT_EMIT_OK) || (ctrl.act == ACT_EMIT_REJ)) && !out_busy;

   // Outcodes: bit 0 left, bit 1 right, bit 2 bottom, bit 3 top.
   assign c1 = {y1_ff > win_top_ff, y1_ff < win_bottom_ff,
                x1_ff > win_right_ff, x1_ff < win_left_ff};
   assign c2 = {y2_ff > win_top_ff, y2_ff < win_bottom_ff,
                x2_ff > win_right_ff, x2_ff < win_left_ff};

   assign status.req_fire   = req_fire;
   assign status.seg_done   = ((c1 | c2) == 4'b0000);
   assign status.seg_reject = ((c1 & c2) != 4'b0000) || (pass_ff == PASS_BITS'(MAX_PASSES));
   assign status.div_more   = (cnt_ff > CNT_W'(1));
   assign status.out_busy   = out_busy;

   // Pass setup: pick the outside endpoint and its highest-priority boundary.
   assign dx         = D'(x2_ff) - D'(x1_ff);
   assign dy         = D'(y2_ff) - D'(y1_ff);
   assign sel_first  = (c1 != 4'b0000);
   assign csel       = sel_first ? c1 : c2;
   assign sel_axis_x = csel[0] || csel[1];
   assign sel_u1     = sel_axis_x ? y1_ff : x1_ff;
   assign sel_v1     = sel_axis_x ? x1_ff : y1_ff;

   always_comb begin
      if (csel[0]) begin
         sel_bnd = win_left_ff;
      end else if (csel[1]) begin
         sel_bnd = win_right_ff;
      end else if (csel[2]) begin
         sel_bnd = win_bottom_ff;
      end else begin
         sel_bnd = win_top_ff;
      end
   end

   // Numerator u1*dv + (B - v1)*du, one product in each of the MUL1 and MUL2 steps.
   assign mul_a   = (ctrl.act == ACT_MUL1) ? D'(u1_ff) : bv_ff;
   assign mul_b   = (ctrl.act == ACT_MUL1) ? dv_ff : du_ff;
   assign prod_in = mul_a * mul_b;

   // Restoring division on magnitudes. The intersection lies between the two
   // endpoints, so the quotient fits in C bits and only C steps are needed.
   assign nmag    = acc_ff[A-1] ? A'(-acc_ff) : A'(acc_ff);
   assign dmag_in = dv_ff[D-1] ? D'(-dv_ff) : D'(dv_ff);
   assign shifted = {rem_ff, quo_ff[C-1]};
   assign trial   = shifted - {1'b0, dmag_ff};

   always_comb begin
      rem_in = nmag[C+D-1:C];
      quo_in = nmag[C-1:0];
      if (ctrl.act == ACT_DIV_STEP) begin
         if (!trial[D]) begin
            rem_in = trial[D-1:0];
            quo_in = {quo_ff[C-2:0], 1'b1};
         end else begin
            rem_in = shifted[D-1:0];
            quo_in = {quo_ff[C-2:0], 1'b0};
         end
      end
   end

   // Write back the moved endpoint. A zero divisor keeps the old coordinate.
   assign qv = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_comb begin
      if (dmag_ff == '0) begin
         if (axis_x_ff) begin
            new_u = first_ff ? y1_ff : y2_ff;
         end else begin
            new_u = first_ff ? x1_ff : x2_ff;
         end
      end else begin
         new_u = signed'(qv);
      end
   end

   always_comb begin
      x1_in = x1_ff;
      y1_in = y1_ff;
      x2_in = x2_ff;
      y2_in = y2_ff;
      if (ctrl.act == ACT_LOAD) begin
         x1_in = req_tdata[C-1:0];
         y1_in = req_tdata[2*C-1:C];
         x2_in = req_tdata[3*C-1:2*C];
         y2_in = req_tdata[4*C-1:3*C];
      end else if (ctrl.act == ACT_WRITE) begin
         if (first_ff) begin
            x1_in = axis_x_ff ? bnd_ff : new_u;
            y1_in = axis_x_ff ? new_u : bnd_ff;
         end else begin
            x2_in = axis_x_ff ? bnd_ff : new_u;
            y2_in = axis_x_ff ? new_u : bnd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= '0;
         win_right_ff  <= '0;
         win_bottom_ff <= '0;
         win_top_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            2'd0:    win_left_ff   <= csr_wdata;
            2'd1:    win_right_ff  <= csr_wdata;
            2'd2:    win_bottom_ff <= csr_wdata;
            2'd3:    win_top_ff    <= csr_wdata;
            default: win_top_ff    <= win_top_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (ctrl.act == ACT_LOAD) begin
            pass_ff <= '0;
         end else if (ctrl.act == ACT_WRITE) begin
            pass_ff <= pass_ff + 1'b1;
         end
         if (ctrl.act == ACT_DIV_LOAD) begin
            cnt_ff <= CNT_W'(C);
         end else if (ctrl.act == ACT_DIV_STEP) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      x2_ff <= x2_in;
      y2_ff <= y2_in;
      if (ctrl.act == ACT_SETUP) begin
         first_ff  <= sel_first;
         axis_x_ff <= sel_axis_x;
         bnd_ff    <= sel_bnd;
         u1_ff     <= sel_u1;
         dv_ff     <= sel_axis_x ? dx : dy;
         du_ff     <= sel_axis_x ? dy : dx;
         bv_ff     <= D'(sel_bnd) - D'(sel_v1);
      end
      if ((ctrl.act == ACT_MUL1) || (ctrl.act == ACT_MUL2)) begin
         prod_ff <= prod_in;
      end
      if (ctrl.act == ACT_MUL2) begin
         acc_ff <= A'(prod_ff);
      end else if (ctrl.act == ACT_ADD) begin
         acc_ff <= acc_ff + A'(prod_ff);
      end
      if (ctrl.act == ACT_DIV_LOAD) begin
         dmag_ff <= dmag_in;
         neg_ff  <= acc_ff[A-1] ^ dv_ff[D-1];
      end
      if ((ctrl.act == ACT_DIV_LOAD) || (ctrl.act == ACT_DIV_STEP)) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Output register: the next request may be taken while this one waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (ctrl.act == ACT_EMIT_OK) begin
            rsp_ok_ff    <= 1'b1;
            rsp_coord_ff <= {y2_ff, x2_ff, y1_ff, x1_ff};
         end else begin
            rsp_ok_ff    <= 1'b0;
            rsp_coord_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = DATA_W'(rsp_coord_ff);

endmodule

`default_nettype wire

FILE: rtl/core/lsrc_seq.sv
// Microcode sequencer for the line segment clipper: step counter, control
// store lookup and conditional jumps. Depends on lsrc_pkg.
`default_nettype none

module lsrc_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lsrc_pkg::seq_status_type status,
   output lsrc_pkg::ctrl_word_type       ctrl
);
   import lsrc_pkg::*;

   logic [PC_BITS-1:0] pc_ff;
   logic [PC_BITS-1:0] pc_in;

   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      pc_in = pc_ff + 1'b1;
      case (ctrl.seq)
         SEQ_NEXT:     pc_in = pc_ff + 1'b1;
         SEQ_GOTO:     pc_in = ctrl.target;
         SEQ_WAIT_REQ: pc_in = status.req_fire ? pc_ff + 1'b1 : pc_ff;
         SEQ_IF_DONE:  pc_in = status.seg_done ? ctrl.target : pc_ff + 1'b1;
         SEQ_IF_REJ:   pc_in = status.seg_reject ? ctrl.target : pc_ff + 1'b1;
         SEQ_LOOP:     pc_in = status.div_more ? ctrl.target : pc_ff + 1'b1;
         SEQ_WAIT_OUT: pc_in = status.out_busy ? pc_ff : ctrl.target;
         default:      pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/lsrc_checker.sv
// Port-level checks for the line segment clipper, bound to
// line_segment_rect_clipper_top. No package dependencies.
`default_nettype none

module lsrc_checker #(
   parameter int COORD_BITS = 12
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [((4*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input wire logic                              rsp_tuser
);

   // A rejected segment reports all coordinates as zero.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rejected response carries nonzero coordinates");

   // The block works on one segment at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a segment is in progress");

   // A response only appears after a segment was being worked on.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared while the block was idle");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind line_segment_rect_clipper_top lsrc_checker #(.COORD_BITS(COORD_BITS)) u_lsrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: tb/line_segment_rect_clipper_top_test.sv
// Self-checking testbench for line_segment_rect_clipper_top: writes clip windows through
// the csr port, streams segments in and checks every response against a predictor.
// Depends on lsrc_pkg and the clipper RTL.
`timescale 1ns / 100ps

module line_segment_rect_clipper_top_test;
   import lsrc_pkg::*;

   localparam int COORD_BITS = 12;
   localparam int DATA_W     = ((4*COORD_BITS+7)/8)*8;
   localparam int COORD_MIN  = -(1 << (COORD_BITS-1));
   localparam int COORD_MAX  = (1 << (COORD_BITS-1)) - 1;

   localparam logic [1:0] REG_LEFT   = 2'd0;
   localparam logic [1:0] REG_RIGHT  = 2'd1;
   localparam logic [1:0] REG_BOTTOM = 2'd2;
   localparam logic [1:0] REG_TOP    = 2'd3;

   localparam logic [3:0] OUT_LEFT   = 4'b0001;
   localparam logic [3:0] OUT_RIGHT  = 4'b0010;
   localparam logic [3:0] OUT_BOTTOM = 4'b0100;
   localparam logic [3:0] OUT_TOP    = 4'b1000;

   typedef logic signed [COORD_BITS-1:0] coord_t;

   typedef struct {
      logic   accepted;
      coord_t sx;
      coord_t sy;
      coord_t ex;
      coord_t ey;
   } clip_result_t;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [1:0]           csr_index  = REG_LEFT;
   logic [COORD_BITS-1:0] csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;

   // Window as the block should hold it.
   coord_t win_left   = '0;
   coord_t win_right  = '0;
   coord_t win_bottom = '0;
   coord_t win_top    = '0;

   clip_result_t pending_clips[$];
   bit idle_enable    = 1'b1;
   int ready_hold     = 0;
   int mismatch_count = 0;
   int segment_count  = 0;
   int visible_count  = 0;
   int window_count   = 0;

   line_segment_rect_clipper_top #(.COORD_BITS(COORD_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [3:0] region_code(input longint x, input longint y);
      logic [3:0] code;
      code = '0;
      if (x < win_left)   code |= OUT_LEFT;
      if (x > win_right)  code |= OUT_RIGHT;
      if (y < win_bottom) code |= OUT_BOTTOM;
      if (y > win_top)    code |= OUT_TOP;
      return code;
   endfunction

   function automatic clip_result_t clip_against_window(input coord_t sx, input coord_t sy,
                                                        input coord_t ex, input coord_t ey);
      longint x1, y1, x2, y2, dx, dy, nx, ny;
      logic [3:0] c1, c2, c;
      bit visible;
      int pass;
      clip_result_t r;
      x1 = sx;
      y1 = sy;
      x2 = ex;
      y2 = ey;
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      visible = 1'b1;
      pass = 0;
      while (pass < MAX_PASSES && (c1 | c2) != 4'b0) begin
         if ((c1 & c2) != 4'b0) begin
            visible = 1'b0;
            break;
         end
         c  = (c1 != 4'b0) ? c1 : c2;
         dx = x2 - x1;
         dy = y2 - y1;
         // A zero divisor leaves the moved endpoint's other coordinate as it was.
         if ((c & (OUT_LEFT | OUT_RIGHT)) != 4'b0) begin
            nx = ((c & OUT_LEFT) != 4'b0) ? longint'(win_left) : longint'(win_right);
            if (dx == 0) ny = (c1 != 4'b0) ? y1 : y2;
            else         ny = (y1 * dx + (nx - x1) * dy) / dx;
         end else begin
            ny = ((c & OUT_BOTTOM) != 4'b0) ? longint'(win_bottom) : longint'(win_top);
            if (dy == 0) nx = (c1 != 4'b0) ? x1 : x2;
            else         nx = (x1 * dy + (ny - y1) * dx) / dy;
         end
         if (c1 != 4'b0) begin
            x1 = nx;
            y1 = ny;
            c1 = region_code(x1, y1);
         end else begin
            x2 = nx;
            y2 = ny;
            c2 = region_code(x2, y2);
         end
         pass++;
      end
      if ((c1 | c2) != 4'b0) visible = 1'b0;
      r.accepted = visible;
      r.sx = visible ? coord_t'(x1) : coord_t'(0);
      r.sy = visible ? coord_t'(y1) : coord_t'(0);
      r.ex = visible ? coord_t'(x2) : coord_t'(0);
      r.ey = visible ? coord_t'(y2) : coord_t'(0);
      return r;
   endfunction

   // Mostly coordinates around the given span so that segments cross the window,
   // with a share drawn from the whole field range.
   function automatic coord_t pick_coord(input int lo, input int hi);
      int a, b;
      if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
      a = (lo - 64 < COORD_MIN) ? COORD_MIN : lo - 64;
      b = (hi + 64 > COORD_MAX) ? COORD_MAX : hi + 64;
      return coord_t'(a + int'($urandom_range(0, b - a)));
   endfunction

   task automatic csr_put(input logic [1:0] idx, input coord_t value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_window(input coord_t l, input coord_t r, input coord_t b,
                               input coord_t t);
      csr_put(REG_LEFT, l);
      csr_put(REG_RIGHT, r);
      csr_put(REG_BOTTOM, b);
      csr_put(REG_TOP, t);
      csr_we     <= 1'b0;
      win_left   = l;
      win_right  = r;
      win_bottom = b;
      win_top    = t;
      window_count++;
   endtask

   // Valid stays high from one request to the next unless a gap is inserted.
   task automatic send_segment(input coord_t sx, input coord_t sy, input coord_t ex,
                               input coord_t ey);
      clip_result_t want;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tdata  <= {ey, ex, sy, sx};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = clip_against_window(sx, sy, ex, ey);
      pending_clips.push_back(want);
      segment_count++;
      if (want.accepted) visible_count++;
   endtask

   task automatic send_random_segment();
      send_segment(pick_coord(win_left, win_right), pick_coord(win_bottom, win_top),
                   pick_coord(win_left, win_right), pick_coord(win_bottom, win_top));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_clips.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic test_reset_window();
      // The window is a single point at the origin until it is written.
      send_segment(0, 0, 0, 0);
      send_segment(-5, -5, 5, 5);
      send_segment(1, 0, 9, 4);
      wait_drained();
   endtask

   task automatic test_boundary_segments();
      write_window(-100, 100, -50, 50);
      send_segment(-10, -10, 20, 30);
      send_segment(-300, 0, -200, 10);
      send_segment(150, 0, 300, 40);
      send_segment(0, -100, 50, -300);
      send_segment(0, 60, 10, 2047);
      send_segment(-300, 0, 0, 10);
      send_segment(0, 0, 500, 25);
      send_segment(10, -400, 20, 0);
      send_segment(-20, 0, 30, 900);
      send_segment(-300, -200, 300, 200);
      send_segment(300, 200, -300, -200);
      send_segment(-200, 40, -40, 200);
      send_segment(-150, 7, 0, -2);
      send_segment(7, -2048, 7, 2047);
      send_segment(-2048, -3, 2047, -3);
      send_segment(-2048, -2048, 2047, 2047);
      send_segment(2047, -2048, -2048, 2047);
      send_segment(-2048, -2048, -2048, -2048);
      wait_drained();
      write_window(-2048, 2047, -2048, 2047);
      send_segment(-2048, 2047, 2047, -2048);
      send_segment(2047, 2047, -2048, -2048);
      wait_drained();
      write_window(2047, 2047, 2047, 2047);
      send_segment(-2048, -2048, 2047, 2047);
      send_segment(2047, -2048, 2047, 2047);
      wait_drained();
      write_window(-2048, -2048, -2048, -2048);
      send_segment(2047, 2047, -2048, -2048);
      send_segment(-2048, 0, 0, -2048);
      wait_drained();
   endtask

   // Left above right or bottom above top: clipping cannot settle inside.
   task automatic test_misordered_window();
      write_window(50, -50, -50, 50);
      send_segment(-100, 0, 100, 0);
      send_segment(0, 0, 0, 0);
      send_segment(-2048, -2048, 2047, 2047);
      wait_drained();
      write_window(-50, 50, 40, -40);
      send_segment(0, -100, 0, 100);
      send_segment(-300, -90, 300, 90);
      wait_drained();
   endtask

   task automatic test_random_windows();
      coord_t a, b, c, d;
      for (int phase = 0; phase < 6; phase++) begin
         a = coord_t'($urandom);
         b = coord_t'($urandom);
         c = coord_t'($urandom);
         d = coord_t'($urandom);
         if (phase == 1) begin
            // Narrow window so that most segments clip on several edges.
            b = a;
            d = c;
         end
         idle_enable = (phase != 2);
         write_window((a < b) ? a : b, (a < b) ? b : a, (c < d) ? c : d, (c < d) ? d : c);
         repeat (65) send_random_segment();
         wait_drained();
      end
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      write_window(-600, 900, -1200, 300);
      repeat (50) send_random_segment();
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         ready_hold <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      clip_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_clips.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, got %0b/%h",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_clips.pop_front();
            check_field("accepted", want.accepted, rsp_tuser);
            check_field("clip_start_x", want.sx, $signed(rsp_tdata[0*COORD_BITS +: COORD_BITS]));
            check_field("clip_start_y", want.sy, $signed(rsp_tdata[1*COORD_BITS +: COORD_BITS]));
            check_field("clip_end_x", want.ex, $signed(rsp_tdata[2*COORD_BITS +: COORD_BITS]));
            check_field("clip_end_y", want.ey, $signed(rsp_tdata[3*COORD_BITS +: COORD_BITS]));
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      test_boundary_segments();
      test_misordered_window();
      test_random_windows();
      test_back_to_back();
      repeat (100) @(posedge clock);
      $display("Clipped %0d segments against %0d windows: %0d visible, %0d rejected.",
               segment_count, window_count + 1, visible_count, segment_count - visible_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/lsrc_pkg.sv
rtl/core/lsrc_seq.sv
rtl/core/line_segment_rect_clipper_top.sv
rtl/core/lsrc_checker.sv
tb/line_segment_rect_clipper_top_test.sv
